>>> rtl/dtts_pkg.sv
// Shared types, codes and unit tables of the duration text parser.
// Used by every module of the block and by the port checker; no dependencies.
package dtts_pkg;

  // Input item: one character, a has-character flag and the end marker
  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } in_item_t;

  // Result item: total seconds and error flag
  typedef struct packed {
    logic [63:0] seconds;
    logic        error;
  } out_item_t;

  // Unit codes, the last one selects the configured bare-number multiplier
  localparam logic [2:0] U_SEC  = 3'd0;
  localparam logic [2:0] U_MIN  = 3'd1;
  localparam logic [2:0] U_MON  = 3'd2;
  localparam logic [2:0] U_HOUR = 3'd3;
  localparam logic [2:0] U_DAY  = 3'd4;
  localparam logic [2:0] U_WEEK = 3'd5;
  localparam logic [2:0] U_CFG  = 3'd6;

  // Work item passed from the parser to the accumulator
  typedef struct packed {
    logic [31:0] num;     // number to scale, zero if nothing to add
    logic [2:0]  code;    // unit code
    logic        is_end;  // text ends with this item
    logic        err;     // text is malformed
  } ev_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } lk_t;

  localparam int Q_DEPTH = 4;

  localparam logic [31:0] MUL_SEC  = 32'd1;
  localparam logic [31:0] MUL_MIN  = 32'd60;
  localparam logic [31:0] MUL_HOUR = 32'(60 * 60);
  localparam logic [31:0] MUL_DAY  = 32'(60 * 60 * 24);
  localparam logic [31:0] MUL_WEEK = 32'(60 * 60 * 24 * 7);
  localparam logic [31:0] MUL_MON  = 32'(60 * 60 * 24 * 30);

  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_W = 8'h77;
  localparam logic [7:0] CH_O = 8'h6f;

  localparam logic [55:0] W_SECOND = "second";
  localparam logic [55:0] W_MINUTE = "minute";
  localparam logic [55:0] W_MONTH  = "month";
  localparam logic [55:0] W_HOUR   = "hour";
  localparam logic [55:0] W_DAY    = "day";
  localparam logic [55:0] W_WEEK   = "week";

  // Match the unit text against one word, with an optional plural s.
  // txt holds character i at bits [8*i +: 8]; w is a right-justified string.
  function automatic logic word_ok(input logic [55:0] txt, input logic [2:0] len,
                                   input logic [55:0] w, input int wl);
    logic ok;
    int   idx;
    ok = (int'(len) == wl) || ((int'(len) == wl + 1) && (txt[8*wl +: 8] == CH_S));
    for (int i = 0; i < 6; i++) begin
      idx = (i < wl) ? (wl - 1 - i) : 0;
      if ((i < wl) && (txt[8*i +: 8] != w[8*idx +: 8])) ok = 1'b0;
    end
    return ok;
  endfunction

  // Decode a complete unit word; len is zero when the word is empty or too long
  function automatic lk_t unit_lookup(input logic [55:0] txt, input logic [2:0] len);
    lk_t res;
    res.ok   = 1'b0;
    res.code = U_SEC;
    case (txt[7:0])
      CH_S: begin
        if (len == 3'd1 || word_ok(txt, len, W_SECOND, 6)) begin
          res.ok = 1'b1; res.code = U_SEC;
        end
      end
      CH_M: begin
        if (len == 3'd1 || word_ok(txt, len, W_MINUTE, 6)) begin
          res.ok = 1'b1; res.code = U_MIN;
        end else if ((len == 3'd2 && txt[15:8] == CH_O) || word_ok(txt, len, W_MONTH, 5)) begin
          res.ok = 1'b1; res.code = U_MON;
        end
      end
      CH_H: begin
        if (len == 3'd1 || word_ok(txt, len, W_HOUR, 4)) begin
          res.ok = 1'b1; res.code = U_HOUR;
        end
      end
      CH_D: begin
        if (len == 3'd1 || word_ok(txt, len, W_DAY, 3)) begin
          res.ok = 1'b1; res.code = U_DAY;
        end
      end
      CH_W: begin
        if (len == 3'd1 || word_ok(txt, len, W_WEEK, 4)) begin
          res.ok = 1'b1; res.code = U_WEEK;
        end
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Seconds per unit for the fixed units
  function automatic logic [31:0] unit_mult(input logic [2:0] code);
    logic [31:0] m;
    case (code)
      U_SEC:   m = MUL_SEC;
      U_MIN:   m = MUL_MIN;
      U_MON:   m = MUL_MON;
      U_HOUR:  m = MUL_HOUR;
      U_DAY:   m = MUL_DAY;
      U_WEEK:  m = MUL_WEEK;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/duration_text_to_seconds.sv
// Top level of the duration text parser: parser, work queue and accumulator.
// Depends on dtts_pkg, dtts_front, dtts_queue and dtts_back.
//
//   channel  ports                          direction  payload
//   input    in_valid/in_ready/in_data      in         in_item_t, one character
//   result   out_valid/out_ready/out_data   out        out_item_t, one per text
//   config   cfg_we/cfg_wdata               in         bare-number multiplier
//
// One character is taken every cycle while the four-entry work queue has room.
// The item marked last passes through the queue, the partial products and the
// combined product, and then accumulates into the result register.
// Reset is synchronous and clears all control state; the multiplier resets to 1.
// A stalled result holds the accumulator; the parser keeps going until the
// queue fills.
module duration_text_to_seconds import dtts_pkg::*; #(
  parameter int UNIT_BUFFER_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  logic acc, ev_push, q_full, q_pop, q_empty;
  ev_t  ev, q_data;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  dtts_front #(.UNIT_BUFFER_LEN(UNIT_BUFFER_LEN)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .ev_push (ev_push),
    .ev      (ev)
  );

  dtts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .wdata (ev),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  dtts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/dtts_front.sv
// Character parser: classifies each item, tracks the number and unit text,
// and emits one work item per unit finished or text ended. Uses dtts_pkg.
module dtts_front import dtts_pkg::*; #(
  parameter int UNIT_BUFFER_LEN = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t in_data,
  output logic     ev_push,
  output ev_t      ev
);

  localparam int LW = $clog2(UNIT_BUFFER_LEN + 2);
  localparam int IW = $clog2(UNIT_BUFFER_LEN);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_NUM    = 3'd1;
  localparam logic [2:0] PH_NUM_SP = 3'd2;
  localparam logic [2:0] PH_UNIT   = 3'd3;
  localparam logic [2:0] PH_GAP    = 3'd4;

  logic [2:0]    phase_r, phase_nxt;
  logic [31:0]   num_r, num_nxt;
  logic          big_r, big_nxt;
  logic [LW-1:0] ulen_r, ulen_nxt;
  logic [7:0]    utxt_r [UNIT_BUFFER_LEN];
  logic          useen_r, useen_nxt;
  logic          cseen_r, cseen_nxt;
  logic          failed_r, failed_nxt;

  logic          take, sp, dg, append, fin_take, fin_end, start_dg;
  logic [7:0]    c;
  logic [3:0]    d;
  logic [35:0]   mul10;
  logic [55:0]   txt7;
  logic [2:0]    len3;
  logic [LW-1:0] len_a;
  lk_t           lk;
  logic          ev_contrib, ev_err;
  logic [31:0]   ev_num;
  logic [2:0]    ev_code;

  assign c     = in_data.char_code;
  assign d     = c[3:0];
  assign take  = in_data.has_char && !failed_r;
  assign sp    = c inside {[8'd9:8'd13], 8'd32, 8'd133, 8'd160};
  assign dg    = c inside {[8'd48:8'd57]};
  assign mul10 = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} + {32'd0, d};

  // Append any character that is neither digit nor space, except after a unit's gap
  assign append = take && !sp && !dg &&
                  (phase_r inside {PH_LEAD, PH_NUM, PH_NUM_SP, PH_UNIT});

  // Unit text as it stands after this character is appended
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      txt7[8*i +: 8] = (append && ulen_r == LW'(i)) ? c : utxt_r[i];
    end
  end
  assign len_a = (append && ulen_r <= LW'(UNIT_BUFFER_LEN)) ? ulen_r + LW'(1) : ulen_r;
  assign len3  = (len_a <= LW'(7)) ? len_a[2:0] : 3'd0;
  assign lk    = unit_lookup(txt7, len3);

  // Next state for one accepted item
  always_comb begin
    phase_nxt  = phase_r;
    num_nxt    = num_r;
    big_nxt    = big_r;
    useen_nxt  = useen_r;
    cseen_nxt  = cseen_r;
    failed_nxt = failed_r;
    fin_take   = 1'b0;
    start_dg   = 1'b0;
    ev_contrib = 1'b0;
    ev_err     = 1'b0;
    ev_num     = num_r;
    ev_code    = lk.code;

    // Classify the character against the current phase
    if (take) begin
      cseen_nxt = 1'b1;
      case (phase_r)
        PH_LEAD: begin
          if (dg) begin
            start_dg = 1'b1;
          end else if (!sp) begin
            num_nxt   = '0;
            big_nxt   = 1'b0;
            phase_nxt = PH_UNIT;
          end
        end
        PH_NUM: begin
          if (dg) begin
            if (!big_r) begin
              if (mul10[35:32] != 4'd0) begin
                big_nxt = 1'b1;
                num_nxt = '0;
              end else begin
                num_nxt = mul10[31:0];
              end
            end
          end else if (sp) begin
            phase_nxt = PH_NUM_SP;
          end else begin
            phase_nxt = PH_UNIT;
          end
        end
        PH_NUM_SP: begin
          if (dg) begin
            failed_nxt = 1'b1;
          end else if (!sp) begin
            phase_nxt = PH_UNIT;
          end
        end
        PH_UNIT: begin
          if (sp) begin
            fin_take  = 1'b1;
            phase_nxt = PH_GAP;
          end else if (dg) begin
            fin_take = 1'b1;
            start_dg = 1'b1;
          end
        end
        default: begin
          if (dg) start_dg = 1'b1;
          else if (!sp) failed_nxt = 1'b1;
        end
      endcase
    end

    ulen_nxt = len_a;

    // Close the unit: on a space or a digit, or at the end of the text
    fin_end = in_data.last && !failed_nxt && (phase_nxt == PH_UNIT);
    if (fin_take || fin_end) begin
      if (lk.ok) begin
        ev_contrib = 1'b1;
        ev_num     = big_r ? 32'd0 : num_r;
        ev_code    = lk.code;
        useen_nxt  = 1'b1;
        num_nxt    = '0;
        big_nxt    = 1'b0;
        ulen_nxt   = '0;
      end else begin
        failed_nxt = 1'b1;
      end
    end

    if (start_dg) begin
      num_nxt   = {28'd0, d};
      big_nxt   = 1'b0;
      phase_nxt = PH_NUM;
    end

    // Decide the result at the end of the text
    if (in_data.last) begin
      if (failed_nxt) begin
        ev_err = 1'b1;
      end else begin
        case (phase_nxt)
          PH_LEAD: ev_err = !cseen_nxt;
          PH_NUM, PH_NUM_SP: begin
            if (useen_nxt) begin
              ev_err = 1'b1;
            end else begin
              ev_contrib = 1'b1;
              ev_num     = big_nxt ? 32'd0 : num_nxt;
              ev_code    = U_CFG;
            end
          end
          default: ev_err = 1'b0;
        endcase
      end
      phase_nxt  = PH_LEAD;
      num_nxt    = '0;
      big_nxt    = 1'b0;
      ulen_nxt   = '0;
      useen_nxt  = 1'b0;
      cseen_nxt  = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  // Drop the addend when the text is already in error
  assign ev_push   = acc && (ev_contrib || in_data.last);
  assign ev.num    = (ev_contrib && !ev_err) ? ev_num : 32'd0;
  assign ev.code   = ev_code;
  assign ev.is_end = in_data.last;
  assign ev.err    = ev_err;

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      num_r    <= '0;
      big_r    <= 1'b0;
      ulen_r   <= '0;
      useen_r  <= 1'b0;
      cseen_r  <= 1'b0;
      failed_r <= 1'b0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      num_r    <= num_nxt;
      big_r    <= big_nxt;
      ulen_r   <= ulen_nxt;
      useen_r  <= useen_nxt;
      cseen_r  <= cseen_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Store unit characters while there is room
  always_ff @(posedge clk) begin
    if (acc && append && ulen_r < LW'(UNIT_BUFFER_LEN)) begin
      utxt_r[ulen_r[IW-1:0]] <= c;
    end
  end

endmodule

>>> rtl/dtts_queue.sv
// Short work-item queue between the parser and the accumulator.
// Register array with read and write pointers; uses dtts_pkg.
module dtts_queue import dtts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  wdata,
  output logic full,
  input  logic pop,
  output ev_t  rdata,
  output logic empty
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  ev_t           mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  // Write entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

>>> rtl/dtts_back.sv
// Accumulator: scales each number by its unit, sums the total and registers
// the result item. Holds the bare-number multiplier register. Uses dtts_pkg.
module dtts_back import dtts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        q_empty,
  input  ev_t         q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [63:0] cfg_r;
  logic        adv;
  logic [63:0] mul;

  logic        v1_r, v2_r;
  logic        end1_r, end2_r;
  logic        err1_r, err2_r;
  logic [63:0] plo_r;
  logic [31:0] phi_r;
  logic [63:0] prod_r;
  logic [63:0] total_r;
  logic [63:0] sum;

  logic        ov_r;
  out_item_t   od_r;

  // Hold the whole pipeline while a result waits and out_ready is low
  assign adv   = !ov_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign mul = (q_data.code == U_CFG) ? cfg_r : {32'd0, unit_mult(q_data.code)};
  assign sum = total_r + prod_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= 64'd1;
    else if (cfg_we) cfg_r <= cfg_wdata;
  end

  // Stage valids and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      ov_r    <= 1'b0;
      total_r <= '0;
    end else if (adv) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      ov_r <= v2_r && end2_r;
      if (v2_r) total_r <= end2_r ? 64'd0 : sum;
    end
  end

  // Payload stages: partial products of the two 32-bit multiplier halves, combine, then accumulate
  always_ff @(posedge clk) begin
    if (adv) begin
      end1_r <= q_data.is_end;
      err1_r <= q_data.err;
      plo_r  <= {32'd0, q_data.num} * {32'd0, mul[31:0]};
      phi_r  <= 32'(q_data.num * mul[63:32]);
      end2_r <= end1_r;
      err2_r <= err1_r;
      prod_r <= plo_r + {phi_r, 32'd0};
      od_r.seconds <= err2_r ? 64'd0 : sum;
      od_r.error   <= err2_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

>>> rtl/dtts_checker.sv
// Port checker for the duration text parser, bound to the top level.
// Sees the top-level ports only; uses dtts_pkg.
module dtts_checker import dtts_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data,
  input logic        cfg_we
);

  // Hold a waiting input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Drop any result on reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Zero the total on error
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.seconds == 64'd0)
    else $error("error result with nonzero seconds");

  // A config write just after reset sees no result
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && cfg_we |-> !out_valid)
    else $error("result right after reset");

endmodule

bind duration_text_to_seconds dtts_checker u_chk (.*);
